// ===== sv/bta_pkg.sv =====
`default_nettype none
package bta_pkg;

  // Pool geometry
  localparam int POOL_WORDS = 1024;
  localparam int AW         = $clog2(POOL_WORDS);
  localparam int PSW        = AW + 1;
  localparam int DW         = 16;
  localparam int XW         = DW + 1;
  localparam int MIN_POOL   = 32;
  localparam int TAG_LIMIT  = 32767;
  localparam int POOL_TOP   = (POOL_WORDS < TAG_LIMIT) ? POOL_WORDS : TAG_LIMIT;
  localparam logic [DW-1:0] NIL_LINK = '1;
  localparam int WHOLE_SLACK = 4;

  // Controller states
  typedef enum logic [5:0] {
    S_CLR_INIT, S_CLR, S_IDLE, S_DONE,
    S_A_CHK, S_A_M, S_A_MC, S_A_E, S_A_NX, S_A_WH1, S_A_WH2, S_A_S1, S_A_S2,
    S_F0, S_F1, S_F1C, S_F2, S_F3, S_F3C, S_F4, S_F5, S_F6, S_F6C, S_F7, S_F_OK,
    S_U0, S_U1, S_U2, S_U3, S_U4,
    S_P0, S_P1, S_P2, S_P3, S_P4
  } state_t;

  // Memory address select
  typedef enum logic [4:0] {
    A_P, A_P_TAG1, A_P2, A_UB1, A_UB2, A_NXT1, A_PRV2, A_START, A_START_SZ1,
    A_START1, A_START2, A_HEAD1, A_U, A_U_REQ1, A_C, A_C_NEGT1, A_NX, A_NX_T1,
    A_CM1, A_PV, A_CNT
  } asel_t;

  // Memory write data select
  typedef enum logic [3:0] {
    W_ZERO, W_NEG_TAG, W_PRV, W_NXT, W_SIZE, W_NIL, W_HEAD, W_START, W_NEG_REQ
  } wsel_t;

  // Datapath register loads
  typedef enum logic [3:0] {
    LD_NONE, LD_ACCEPT, LD_TAG, LD_NEXT, LD_UB_P, LD_SPLIT, LD_PRV, LD_NXT,
    LD_HEAD_UNL, LD_HEAD_PUSH, LD_FSTART, LD_NXMERGE, LD_PVMERGE, LD_CLR_INIT,
    LD_CNT_INC
  } ld_t;

  // Result capture
  typedef enum logic [2:0] {
    RES_NONE, RES_FAIL, RES_WHOLE, RES_SPLIT, RES_FREE
  } res_t;

  typedef struct packed {
    logic  mem_rd;
    logic  mem_wr;
    asel_t asel;
    wsel_t wsel;
    ld_t   ld;
    res_t  res;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic a_stop;
    logic node_ok;
    logic end_match;
    logic fits;
    logic whole;
    logic f_tag_ok;
    logic nx_in;
    logic tn_ok;
    logic c_zero;
    logic tp_ok;
    logic a_zero;
    logic clr_last;
  } stat_t;

  // Clamp a written pool size into the usable range
  function automatic logic [PSW-1:0] clamp_pool(input logic [PSW-1:0] v);
    logic [PSW-1:0] r;
    r = v;
    if (r < PSW'(MIN_POOL)) r = PSW'(MIN_POOL);
    if (r > PSW'(POOL_TOP)) r = PSW'(POOL_TOP);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bta_ram.sv =====
`default_nettype none
module bta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/bta_ctrl.sv =====
`default_nettype none
module bta_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_mode,
  input  wire logic          out_ready,
  input  wire logic          cfg_valid,
  input  wire bta_pkg::stat_t stat,
  output bta_pkg::cmd_t      cmd,
  output logic               in_ready,
  output logic               out_valid
);
  import bta_pkg::*;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  state_t pret_r, pret_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    pret_nxt  = pret_r;
    case (state_r)
      S_CLR_INIT: begin
        pret_nxt  = S_IDLE;
        state_nxt = S_CLR;
      end
      S_CLR:      if (stat.clr_last) state_nxt = S_P0;
      S_IDLE: begin
        if (in_valid && !cfg_valid) begin
          if (in_mode) begin
            pret_nxt  = S_F_OK;
            state_nxt = S_F0;
          end else begin
            state_nxt = S_A_CHK;
          end
        end
      end
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      // allocate: walk the free list
      S_A_CHK:    state_nxt = stat.a_stop ? S_DONE : S_A_M;
      S_A_M:      state_nxt = S_A_MC;
      S_A_MC:     state_nxt = stat.node_ok ? S_A_E : S_DONE;
      S_A_E: begin
        if (!stat.end_match) begin
          state_nxt = S_DONE;
        end else if (stat.fits) begin
          state_nxt = S_U0;
          if (stat.whole) begin
            ret_nxt = S_A_WH1;
          end else begin
            ret_nxt  = S_P0;
            pret_nxt = S_A_S1;
          end
        end else begin
          state_nxt = S_A_NX;
        end
      end
      S_A_NX:     state_nxt = S_A_CHK;
      S_A_WH1:    state_nxt = S_A_WH2;
      S_A_WH2:    state_nxt = S_DONE;
      S_A_S1:     state_nxt = S_A_S2;
      S_A_S2:     state_nxt = S_DONE;
      // free: check block, merge neighbours
      S_F0:       state_nxt = stat.a_zero ? S_DONE : S_F1;
      S_F1:       state_nxt = S_F1C;
      S_F1C:      state_nxt = stat.f_tag_ok ? S_F2 : S_DONE;
      S_F2: begin
        if (!stat.end_match) state_nxt = S_DONE;
        else                 state_nxt = stat.nx_in ? S_F3 : S_F5;
      end
      S_F3:       state_nxt = S_F3C;
      S_F3C:      state_nxt = stat.tn_ok ? S_F4 : S_F5;
      S_F4: begin
        if (stat.end_match) begin
          ret_nxt   = S_F5;
          state_nxt = S_U0;
        end else begin
          state_nxt = S_F5;
        end
      end
      S_F5:       state_nxt = stat.c_zero ? S_P0 : S_F6;
      S_F6:       state_nxt = S_F6C;
      S_F6C:      state_nxt = stat.tp_ok ? S_F7 : S_P0;
      S_F7: begin
        if (stat.end_match) begin
          ret_nxt   = S_P0;
          state_nxt = S_U0;
        end else begin
          state_nxt = S_P0;
        end
      end
      S_F_OK:     state_nxt = S_DONE;
      // unlink
      S_U0:       state_nxt = S_U1;
      S_U1:       state_nxt = S_U2;
      S_U2:       state_nxt = S_U3;
      S_U3:       state_nxt = S_U4;
      S_U4:       state_nxt = ret_r;
      // push at head
      S_P0:       state_nxt = S_P1;
      S_P1:       state_nxt = S_P2;
      S_P2:       state_nxt = S_P3;
      S_P3:       state_nxt = S_P4;
      S_P4:       state_nxt = pret_r;
      default:    state_nxt = S_CLR_INIT;
    endcase
    if (cfg_valid) state_nxt = S_CLR_INIT;
  end

  // Commands
  always_comb begin
    cmd = cmd_t'('0);
    case (state_r)
      S_CLR_INIT: cmd.ld = LD_CLR_INIT;
      S_CLR: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_CNT;
        cmd.wsel   = W_ZERO;
        cmd.ld     = LD_CNT_INC;
      end
      S_IDLE:     if (in_valid && !cfg_valid) cmd.ld = LD_ACCEPT;
      S_DONE:     cmd.out_load = out_free;
      S_A_CHK: begin
        if (stat.a_stop) begin
          cmd.res = RES_FAIL;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = A_P;
        end
      end
      S_A_M:      cmd.ld = LD_TAG;
      S_A_MC: begin
        if (stat.node_ok) begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = A_P_TAG1;
        end else begin
          cmd.res = RES_FAIL;
        end
      end
      S_A_E: begin
        if (!stat.end_match) begin
          cmd.res = RES_FAIL;
        end else if (stat.fits) begin
          cmd.ld = stat.whole ? LD_UB_P : LD_SPLIT;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = A_P2;
        end
      end
      S_A_NX:     cmd.ld = LD_NEXT;
      S_A_WH1: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_P;
        cmd.wsel   = W_NEG_TAG;
      end
      S_A_WH2: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_P_TAG1;
        cmd.wsel   = W_NEG_TAG;
        cmd.res    = RES_WHOLE;
      end
      S_A_S1: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_U;
        cmd.wsel   = W_NEG_REQ;
      end
      S_A_S2: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_U_REQ1;
        cmd.wsel   = W_NEG_REQ;
        cmd.res    = RES_SPLIT;
      end
      S_F0: begin
        if (stat.a_zero) begin
          cmd.res = RES_FAIL;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = A_C;
        end
      end
      S_F1:       cmd.ld = LD_TAG;
      S_F1C: begin
        if (stat.f_tag_ok) begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = A_C_NEGT1;
          cmd.ld     = LD_FSTART;
        end else begin
          cmd.res = RES_FAIL;
        end
      end
      S_F2: begin
        if (!stat.end_match) begin
          cmd.res = RES_FAIL;
        end else if (stat.nx_in) begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = A_NX;
        end
      end
      S_F3:       cmd.ld = LD_TAG;
      S_F3C: begin
        if (stat.tn_ok) begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = A_NX_T1;
        end
      end
      S_F4:       if (stat.end_match) cmd.ld = LD_NXMERGE;
      S_F5: begin
        if (!stat.c_zero) begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = A_CM1;
        end
      end
      S_F6:       cmd.ld = LD_TAG;
      S_F6C: begin
        if (stat.tp_ok) begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = A_PV;
        end
      end
      S_F7:       if (stat.end_match) cmd.ld = LD_PVMERGE;
      S_F_OK:     cmd.res = RES_FREE;
      S_U0: begin
        cmd.mem_rd = 1'b1;
        cmd.asel   = A_UB1;
      end
      S_U1: begin
        cmd.mem_rd = 1'b1;
        cmd.asel   = A_UB2;
        cmd.ld     = LD_PRV;
      end
      S_U2:       cmd.ld = LD_NXT;
      S_U3: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_NXT1;
        cmd.wsel   = W_PRV;
      end
      S_U4: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_PRV2;
        cmd.wsel   = W_NXT;
        cmd.ld     = LD_HEAD_UNL;
      end
      S_P0: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_START;
        cmd.wsel   = W_SIZE;
      end
      S_P1: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_START_SZ1;
        cmd.wsel   = W_SIZE;
      end
      S_P2: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_START1;
        cmd.wsel   = W_NIL;
      end
      S_P3: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_START2;
        cmd.wsel   = W_HEAD;
      end
      S_P4: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = A_HEAD1;
        cmd.wsel   = W_START;
        cmd.ld     = LD_HEAD_PUSH;
      end
      default:    cmd = cmd_t'('0);
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_ready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR_INIT;
      ret_r       <= S_IDLE;
      pret_r      <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      pret_r      <= pret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bta_datapath.sv =====
`default_nettype none
module bta_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_valid,
  input  wire logic [bta_pkg::PSW-1:0] cfg_pool_size,
  input  wire logic [9:0]              in_request_size,
  input  wire logic [9:0]              in_block_address,
  input  wire bta_pkg::cmd_t           cmd,
  output bta_pkg::stat_t               stat,
  output logic [9:0]                   out_payload_address,
  output logic                         out_status
);
  import bta_pkg::*;

  logic [PSW-1:0] ps_r;
  logic [DW-1:0]  head_r, p_r, tag_r, ub_r, start_r, size_r, prv_r, nxt_r, u_r;
  logic [9:0]     req_r, c_r;
  logic [PSW-1:0] cnt_r;
  logic           a_zero_r, inrange_r;
  logic [9:0]     res_addr_r, out_addr_r;
  logic           res_status_r, out_status_r;

  logic [DW-1:0]  ram_q, rd_val, neg_tag, wdata, pv;
  logic [XW-1:0]  addr_x, ps_x, nx_x;
  logic           addr_in, tag_free_ok;

  assign ps_x    = XW'(ps_r);
  assign rd_val  = inrange_r ? ram_q : '0;
  assign neg_tag = ~tag_r + DW'(1);
  assign nx_x    = XW'(c_r) + XW'(size_r) + XW'(2);
  assign pv      = DW'(c_r) - tag_r - DW'(2);

  // Address select
  always_comb begin
    case (cmd.asel)
      A_P:         addr_x = XW'(p_r);
      A_P_TAG1:    addr_x = XW'(p_r) + XW'(tag_r) + XW'(1);
      A_P2:        addr_x = XW'(p_r) + XW'(2);
      A_UB1:       addr_x = XW'(ub_r) + XW'(1);
      A_UB2:       addr_x = XW'(ub_r) + XW'(2);
      A_NXT1:      addr_x = XW'(nxt_r) + XW'(1);
      A_PRV2:      addr_x = XW'(prv_r) + XW'(2);
      A_START:     addr_x = XW'(start_r);
      A_START_SZ1: addr_x = XW'(start_r) + XW'(size_r) + XW'(1);
      A_START1:    addr_x = XW'(start_r) + XW'(1);
      A_START2:    addr_x = XW'(start_r) + XW'(2);
      A_HEAD1:     addr_x = XW'(head_r) + XW'(1);
      A_U:         addr_x = XW'(u_r);
      A_U_REQ1:    addr_x = XW'(u_r) + XW'(req_r) + XW'(1);
      A_C:         addr_x = XW'(c_r);
      A_C_NEGT1:   addr_x = XW'(c_r) + XW'(neg_tag) + XW'(1);
      A_NX:        addr_x = nx_x;
      A_NX_T1:     addr_x = nx_x + XW'(tag_r) + XW'(1);
      A_CM1:       addr_x = XW'(c_r) - XW'(1);
      A_PV:        addr_x = XW'(pv);
      A_CNT:       addr_x = XW'(cnt_r);
      default:     addr_x = '0;
    endcase
  end

  // Write data select
  always_comb begin
    case (cmd.wsel)
      W_ZERO:    wdata = '0;
      W_NEG_TAG: wdata = neg_tag;
      W_PRV:     wdata = prv_r;
      W_NXT:     wdata = nxt_r;
      W_SIZE:    wdata = size_r;
      W_NIL:     wdata = NIL_LINK;
      W_HEAD:    wdata = head_r;
      W_START:   wdata = start_r;
      W_NEG_REQ: wdata = DW'(0) - DW'(req_r);
      default:   wdata = '0;
    endcase
  end

  // Accesses outside the pool read 0 and drop writes
  assign addr_in = addr_x < ps_x;

  bta_ram #(.WIDTH(DW), .DEPTH(POOL_WORDS)) u_pool (
    .clk   (clk),
    .we    (cmd.mem_wr && addr_in),
    .re    (cmd.mem_rd),
    .addr  (addr_x[AW-1:0]),
    .wdata (wdata),
    .rdata (ram_q)
  );

  // Status
  assign tag_free_ok    = !tag_r[DW-1] && (tag_r >= DW'(2));
  assign stat.a_stop    = (cnt_r >= ps_r) || (XW'(p_r) >= ps_x);
  assign stat.node_ok   = tag_free_ok && (XW'(p_r) + XW'(tag_r) + XW'(1) < ps_x);
  assign stat.end_match = rd_val == tag_r;
  assign stat.fits      = tag_r >= DW'(req_r);
  assign stat.whole     = XW'(tag_r) <= XW'(req_r) + XW'(WHOLE_SLACK);
  assign stat.f_tag_ok  = tag_r[DW-1] && (neg_tag >= DW'(2))
                          && (XW'(c_r) + XW'(neg_tag) + XW'(1) < ps_x);
  assign stat.nx_in     = nx_x < ps_x;
  assign stat.tn_ok     = tag_free_ok && (nx_x + XW'(tag_r) + XW'(1) < ps_x);
  assign stat.c_zero    = c_r == '0;
  assign stat.tp_ok     = tag_free_ok && (XW'(c_r) >= XW'(tag_r) + XW'(2));
  assign stat.a_zero    = a_zero_r;
  assign stat.clr_last  = cnt_r == ps_r - PSW'(1);

  // Pool size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= clamp_pool(PSW'(POOL_WORDS));
    end else if (cfg_valid) begin
      ps_r <= clamp_pool(cfg_pool_size);
    end
  end

  // Read range flag follows the RAM read
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      inrange_r <= addr_in;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.ld)
      LD_ACCEPT: begin
        req_r    <= (in_request_size < 10'd2) ? 10'd2 : in_request_size;
        p_r      <= head_r;
        cnt_r    <= '0;
        c_r      <= in_block_address - 10'd1;
        a_zero_r <= in_block_address == '0;
      end
      LD_TAG:       tag_r <= rd_val;
      LD_NEXT: begin
        p_r   <= rd_val;
        cnt_r <= cnt_r + PSW'(1);
      end
      LD_UB_P:      ub_r <= p_r;
      LD_SPLIT: begin
        ub_r    <= p_r;
        start_r <= p_r;
        size_r  <= tag_r - DW'(req_r) - DW'(2);
        u_r     <= p_r + tag_r - DW'(req_r);
      end
      LD_PRV:       prv_r <= rd_val;
      LD_NXT:       nxt_r <= rd_val;
      LD_HEAD_UNL: begin
        if (XW'(prv_r) >= ps_x) begin
          head_r <= (XW'(nxt_r) < ps_x) ? nxt_r : NIL_LINK;
        end
      end
      LD_HEAD_PUSH: head_r <= start_r;
      LD_FSTART: begin
        start_r <= DW'(c_r);
        size_r  <= neg_tag;
      end
      LD_NXMERGE: begin
        ub_r   <= nx_x[DW-1:0];
        size_r <= size_r + tag_r + DW'(2);
      end
      LD_PVMERGE: begin
        ub_r    <= pv;
        start_r <= pv;
        size_r  <= size_r + tag_r + DW'(2);
      end
      LD_CLR_INIT: begin
        cnt_r   <= '0;
        head_r  <= NIL_LINK;
        start_r <= '0;
        size_r  <= DW'(ps_r) - DW'(2);
      end
      LD_CNT_INC:   cnt_r <= cnt_r + PSW'(1);
      default: ;
    endcase
  end

  // Result capture and output register
  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_FAIL: begin
        res_addr_r   <= '0;
        res_status_r <= 1'b1;
      end
      RES_WHOLE: begin
        res_addr_r   <= p_r[9:0] + 10'd1;
        res_status_r <= 1'b0;
      end
      RES_SPLIT: begin
        res_addr_r   <= u_r[9:0] + 10'd1;
        res_status_r <= 1'b0;
      end
      RES_FREE: begin
        res_addr_r   <= '0;
        res_status_r <= 1'b0;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_payload_address = out_addr_r;
  assign out_status          = out_status_r;

endmodule
`default_nettype wire

// ===== sv/boundary_tag_allocator.sv =====
// Sequence, after a request is taken: an allocate walks the free list block by block,
//   then unlinks a whole block and marks it used, or splits it and pushes the low part back;
//   a free checks the block, merges free neighbours on both sides and pushes the result.
// Throughput: one request at a time; the single-port pool memory and the list walk set it.
// Reset (rst_n, synchronous) and any pool_size write clear the first pool_size words
//   one a cycle and format one free block, with no request taken meanwhile.
`default_nettype none
module boundary_tag_allocator (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_mode,
  input  wire logic [9:0]              in_request_size,
  input  wire logic [9:0]              in_block_address,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [9:0]                   out_payload_address,
  output logic                         out_status,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [bta_pkg::PSW-1:0] cfg_pool_size
);
  import bta_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  bta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  bta_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_pool_size       (cfg_pool_size),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .cmd                 (cmd),
    .stat                (stat),
    .out_payload_address (out_payload_address),
    .out_status          (out_status)
  );

  // A taken request keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a request was taken");

  // A pool_size write starts the clearing pass
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input open right after pool reformat");

  // A refused request never carries an address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_payload_address == '0)
    else $error("refused request with nonzero address");

endmodule
`default_nettype wire

// ===== tb/boundary_tag_allocator_tb.sv =====
`default_nettype none
module boundary_tag_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bta_pkg::*;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_NONE    = 1'b1;
  localparam int   SETTLE     = 80;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_mode;
  logic [9:0]       in_request_size;
  logic [9:0]       in_block_address;
  logic             out_valid;
  logic             out_ready;
  logic [9:0]       out_payload_address;
  logic             out_status;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [PSW-1:0]   cfg_pool_size;

  boundary_tag_allocator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_request_size    (in_request_size),
    .in_block_address   (in_block_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_payload_address(out_payload_address),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_pool_size      (cfg_pool_size)
  );

  typedef struct {
    logic [9:0] addr;
    logic       status;
  } grant_t;

  typedef struct {
    logic       mode;
    logic [9:0] size;
    logic [9:0] addr;
    bit         typed;
    logic [9:0] exp_addr;
    logic       exp_status;
  } row_t;

  // Predictor state: the heap image, list head and pool size in words
  logic [15:0]  heap_mem [POOL_WORDS];
  int unsigned  heap_head;
  int unsigned  heap_words;

  grant_t       grant_q[$];
  int unsigned  live_blocks[$];
  int           errors;
  bit           calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic int unsigned heap_rd(input int unsigned a);
    return (a < heap_words) ? heap_mem[a] : 0;
  endfunction

  function automatic void heap_wr(input int unsigned a, input int unsigned v);
    if (a < heap_words) heap_mem[a] = v[15:0];
  endfunction

  function automatic bit tag_is_free(input int unsigned t);
    return t != 0 && t[15] == 1'b0;
  endfunction

  function automatic void list_unlink(input int unsigned b);
    int unsigned prv;
    int unsigned nxt;
    prv = heap_rd(b + 1);
    nxt = heap_rd(b + 2);
    if (nxt < heap_words) heap_wr(nxt + 1, prv);
    if (prv < heap_words) heap_wr(prv + 2, nxt);
    else heap_head = (nxt < heap_words) ? nxt : 32'hFFFF;
  endfunction

  function automatic void list_push(input int unsigned b, input int unsigned m);
    heap_wr(b, m);
    heap_wr(b + m + 1, m);
    heap_wr(b + 1, 32'hFFFF);
    heap_wr(b + 2, heap_head);
    if (heap_head < heap_words) heap_wr(heap_head + 1, b);
    heap_head = b;
  endfunction

  function automatic void heap_format(input int unsigned words);
    if (words < MIN_POOL) words = MIN_POOL;
    if (words > POOL_TOP) words = POOL_TOP;
    heap_words = words;
    foreach (heap_mem[i]) heap_mem[i] = '0;
    heap_head = 32'hFFFF;
    list_push(0, heap_words - 2);
  endfunction

  function automatic bit node_ok(input int unsigned b, input int unsigned t);
    return tag_is_free(t) && t >= 2 && b + t + 1 < heap_words && heap_rd(b + t + 1) == t;
  endfunction

  // First-fit search: whole block when the slack is small, else split off the top
  function automatic grant_t predict_alloc(input int unsigned req);
    grant_t      g;
    int unsigned p;
    int unsigned m;
    int unsigned low;
    int unsigned u;
    g.addr = '0;
    g.status = ST_NONE;
    p = heap_head;
    if (req < 2) req = 2;
    for (int unsigned n = 0; n < heap_words && p < heap_words; n++) begin
      m = heap_rd(p);
      if (!node_ok(p, m)) break;
      if (m >= req) begin
        list_unlink(p);
        if (m <= req + WHOLE_SLACK) begin
          heap_wr(p, 32'h10000 - m);
          heap_wr(p + m + 1, 32'h10000 - m);
          u = p;
        end else begin
          low = m - req - 2;
          u = p + low + 2;
          list_push(p, low);
          heap_wr(u, 32'h10000 - req);
          heap_wr(u + req + 1, 32'h10000 - req);
        end
        g.addr = 10'(u + 1);
        g.status = ST_DONE;
        return g;
      end
      p = heap_rd(p + 2);
    end
    return g;
  endfunction

  // Release with merging of free neighbours on both sides
  function automatic grant_t predict_free(input int unsigned addr);
    grant_t      g;
    int unsigned c;
    int unsigned t;
    int unsigned m;
    int unsigned start;
    int unsigned sz;
    int unsigned nx;
    int unsigned tn;
    int unsigned tp;
    int unsigned pv;
    g.addr = '0;
    g.status = ST_NONE;
    if (addr < 1) return g;
    c = addr - 1;
    t = heap_rd(c);
    if (t[15] == 1'b0) return g;
    m = 32'h10000 - t;
    if (m < 2 || c + m + 1 >= heap_words || heap_rd(c + m + 1) != t) return g;
    start = c;
    sz = m;
    nx = c + m + 2;
    if (nx < heap_words) begin
      tn = heap_rd(nx);
      if (node_ok(nx, tn)) begin
        list_unlink(nx);
        sz += tn + 2;
      end
    end
    if (c > 0) begin
      tp = heap_rd(c - 1);
      if (tag_is_free(tp) && tp >= 2 && c >= tp + 2) begin
        pv = c - tp - 2;
        if (heap_rd(pv) == tp) begin
          list_unlink(pv);
          start = pv;
          sz += tp + 2;
        end
      end
    end
    list_push(start, sz);
    g.status = ST_DONE;
    return g;
  endfunction

  function automatic int unsigned draw_gap();
    if (calm) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // Issue one request and record what it should produce
  task automatic send_request(input row_t r);
    grant_t g;
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= r.mode;
    in_request_size  <= r.size;
    in_block_address <= r.addr;
    do @(posedge clk); while (!in_ready);
    if (r.mode == MODE_ALLOC) begin
      g = predict_alloc(r.size);
      if (g.status == ST_DONE) live_blocks.push_back(g.addr);
    end else begin
      g = predict_free(r.addr);
    end
    if (r.typed) begin
      g.addr = r.exp_addr;
      g.status = r.exp_status;
    end
    grant_q.push_back(g);
  endtask

  task automatic drain();
    while (grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_pool(input int unsigned words);
    in_valid <= 1'b0;
    drain();
    cfg_valid     <= 1'b1;
    cfg_pool_size <= PSW'(words);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    heap_format(words);
    live_blocks.delete();
  endtask

  // Mostly allocate/release of live blocks, with odd sizes and stray releases
  task automatic random_phase(input int count);
    row_t r;
    int unsigned k;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      r.typed = 1'b0;
      r.size = 10'($urandom);
      r.addr = 10'($urandom);
      if (live_blocks.size() == 0 || $urandom_range(0, 99) < 55) begin
        r.mode = MODE_ALLOC;
        k = $urandom_range(0, 99);
        if (k < 85) r.size = 10'($urandom_range(1, 40));
        else if (k < 95) r.size = 10'($urandom_range(41, 400));
        else if (k < 98) r.size = 10'($urandom_range(401, 1023));
        else r.size = 10'($urandom_range(0, 1));
      end else begin
        r.mode = MODE_FREE;
        if ($urandom_range(0, 99) < 85) begin
          k = $urandom_range(0, live_blocks.size() - 1);
          r.addr = 10'(live_blocks[k]);
          live_blocks.delete(k);
        end
      end
      send_request(r);
    end
    calm = 1'b0;
  endtask

  // Result side: random back-pressure, compare against the oldest expectation
  initial begin
    grant_t  g;
    out_ready = 1'b0;
    forever begin
      int unsigned stall;
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (grant_q.size() == 0) begin
        report("result with nothing outstanding");
      end else begin
        g = grant_q.pop_front();
        if (out_payload_address !== g.addr)
          report($sformatf("payload_address %0d, wanted %0d", out_payload_address, g.addr));
        if (out_status !== g.status)
          report($sformatf("status %0d, wanted %0d", out_status, g.status));
      end
    end
  end

  // Directed rows: typed results only where they follow directly from a fresh pool
  row_t directed [] = '{
    '{MODE_ALLOC, 10'd1,    10'd0,    1'b1, 10'd1021, ST_DONE},
    '{MODE_FREE,  10'd0,    10'd0,    1'b1, 10'd0,    ST_NONE},
    '{MODE_ALLOC, 10'd1022, 10'd0,    1'b1, 10'd0,    ST_NONE},
    '{MODE_FREE,  10'd0,    10'd1021, 1'b1, 10'd0,    ST_DONE},
    '{MODE_ALLOC, 10'd1022, 10'd1023, 1'b1, 10'd1,    ST_DONE},
    '{MODE_ALLOC, 10'd1,    10'd0,    1'b1, 10'd0,    ST_NONE},
    '{MODE_FREE,  10'd1023, 10'd1,    1'b1, 10'd0,    ST_DONE},
    '{MODE_FREE,  10'd0,    10'd1,    1'b1, 10'd0,    ST_NONE},
    '{MODE_ALLOC, 10'd1023, 10'd0,    1'b0, 10'd0,    ST_DONE},
    '{MODE_ALLOC, 10'd0,    10'd0,    1'b0, 10'd0,    ST_DONE},
    '{MODE_ALLOC, 10'd1015, 10'd0,    1'b0, 10'd0,    ST_DONE},
    '{MODE_ALLOC, 10'd5,    10'd0,    1'b0, 10'd0,    ST_DONE},
    '{MODE_FREE,  10'd0,    10'd1022, 1'b0, 10'd0,    ST_DONE},
    '{MODE_FREE,  10'd0,    10'd1023, 1'b0, 10'd0,    ST_DONE},
    '{MODE_FREE,  10'd0,    10'd1018, 1'b0, 10'd0,    ST_DONE},
    '{MODE_ALLOC, 10'd3,    10'd0,    1'b0, 10'd0,    ST_DONE},
    '{MODE_ALLOC, 10'd7,    10'd0,    1'b0, 10'd0,    ST_DONE},
    '{MODE_FREE,  10'd0,    10'd3,    1'b0, 10'd0,    ST_DONE},
    '{MODE_FREE,  10'd0,    10'd512,  1'b0, 10'd0,    ST_DONE},
    '{MODE_FREE,  10'd0,    10'd1,    1'b0, 10'd0,    ST_DONE}
  };

  initial begin
    errors           = 0;
    calm             = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_mode          = 1'b0;
    in_request_size  = '0;
    in_block_address = '0;
    cfg_valid        = 1'b0;
    cfg_pool_size    = '0;
    heap_format(1024);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_request(directed[i]);
    random_phase(60);

    // Pool sizes: smallest, below range, above range, odd middle, full
    write_pool(32);
    random_phase(50);
    write_pool(0);
    random_phase(20);
    write_pool(2047);
    random_phase(200);
    write_pool(101);
    random_phase(100);
    write_pool(1024);
    random_phase(170);

    in_valid <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
